// ===== rtl/core/hrs_pkg.sv =====
// Package for the hopper refill sequencer: payload and state types, phase
// codes and packing widths. No dependencies.
package hrs_pkg;

  localparam int unsigned TimeW     = 32;
  localparam int unsigned InBits    = TimeW + 11;
  localparam int unsigned InDataW   = ((InBits + 7) / 8) * 8;
  localparam int unsigned OutBits   = 8;
  localparam int unsigned OutDataW  = ((OutBits + 7) / 8) * 8;
  localparam int unsigned CfgIndexW = 1;
  localparam int unsigned CfgDataW  = 32;

  // Configuration register indexes
  localparam logic [CfgIndexW-1:0] RegTimeLimit = 1'd0;
  localparam logic [CfgIndexW-1:0] RegEnable    = 1'd1;

  // Phase codes as reported on the result
  localparam logic [1:0] PhaseCodeIdle     = 2'd0;
  localparam logic [1:0] PhaseCodeStarting = 2'd1;
  localparam logic [1:0] PhaseCodeRunning  = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'b001,
    PH_STARTING = 3'b010,
    PH_RUNNING  = 3'b100
  } phase_t;

  typedef struct packed {
    logic             release_inhibit;
    logic             weight_above_max;
    logic             release_toggle;
    logic             sw_release_value;
    logic             sw_release_write;
    logic             panel_stop;
    logic             panel_start;
    logic             startstop_level;
    logic             stop_level;
    logic             request_level;
    logic             release_level;
    logic [TimeW-1:0] time_now;
  } tick_t;

  typedef struct packed {
    phase_t           phase;
    logic [TimeW-1:0] start_time;
    logic             release_latch;
    logic [3:0]       prev_levels;  // startstop, stop, request, release
    logic             panel_used;
    logic             software_used;
    logic             st_refill;
    logic             st_start;
    logic             st_stop;
    logic             st_alarm;
  } seq_state_t;

  typedef struct packed {
    logic       control_enabled;
    logic [1:0] phase;
    logic       timeout_alarm;
    logic       stop_state;
    logic       start_state;
    logic       release_state;
    logic       refill_active;
  } status_t;

  typedef struct packed {
    logic [TimeW-1:0] time_limit;
    logic             enable;
  } cfg_t;

endpackage

// ===== rtl/core/hrs_step.sv =====
// Next-state and status logic for one control tick of the refill sequencer.
// Depends on hrs_pkg.
module hrs_step (
  input  hrs_pkg::tick_t      tick,
  input  hrs_pkg::seq_state_t cur,
  input  hrs_pkg::cfg_t       cfg,
  output hrs_pkg::seq_state_t nxt,
  output hrs_pkg::status_t    status
);

  always_comb begin
    logic                     io_rel_start;
    logic                     io_rel_stop;
    logic                     sw_rel_start;
    logic                     sw_rel_stop;
    logic                     io_start;
    logic                     io_stop;
    logic                     ss_edge;
    logic                     rs;
    logic                     decide;
    logic                     done;
    logic                     refill;
    logic [hrs_pkg::TimeW-1:0] deadline;

    nxt          = cur;
    io_rel_start = tick.release_level;
    io_rel_stop  = !tick.release_level && cur.prev_levels[0];
    ss_edge      = tick.startstop_level || cur.prev_levels[3];
    io_start     = ss_edge ? tick.startstop_level : tick.request_level;
    io_stop      = ss_edge ? !tick.startstop_level : tick.stop_level;
    sw_rel_start = 1'b0;
    sw_rel_stop  = 1'b0;
    rs           = cur.release_latch;
    decide       = 1'b0;
    done         = 1'b0;
    refill       = 1'b0;
    deadline     = cur.start_time + cfg.time_limit;

    if (cfg.enable) begin
      // stored levels always follow the inputs
      nxt.prev_levels = {tick.startstop_level, tick.stop_level,
                         tick.request_level, tick.release_level};
      if (tick.panel_start || tick.panel_stop) nxt.panel_used = 1'b1;
      // toggle overrides a software write in the same tick
      if (tick.release_toggle) begin
        sw_rel_stop       = cur.release_latch;
        sw_rel_start      = !cur.release_latch;
        nxt.software_used = 1'b1;
      end else if (tick.sw_release_write) begin
        sw_rel_start      = tick.sw_release_value;
        sw_rel_stop       = !tick.sw_release_value;
        nxt.software_used = 1'b1;
      end

      if (rs) begin
        if (tick.release_inhibit || sw_rel_stop || io_rel_stop) rs = 1'b0;
      end else if (io_rel_start || sw_rel_start) begin
        rs = 1'b1;
      end
      nxt.release_latch = rs;
      if (!rs) nxt.st_alarm = 1'b0;

      case (cur.phase)
        hrs_pkg::PH_STARTING: begin
          decide      = !rs || io_stop || tick.panel_stop;
          nxt.st_stop = decide;
          done        = decide || tick.weight_above_max;
          if (done) begin
            nxt.st_refill = 1'b0;
            nxt.phase     = hrs_pkg::PH_IDLE;
          end else if (tick.time_now > deadline) begin
            nxt.st_alarm = 1'b1;
            nxt.phase    = hrs_pkg::PH_RUNNING;
          end
        end
        hrs_pkg::PH_RUNNING: begin
          decide      = !rs || io_stop || tick.panel_stop;
          nxt.st_stop = decide;
          done        = decide || tick.weight_above_max;
          if (done) begin
            nxt.st_alarm  = 1'b0;
            nxt.st_refill = 1'b0;
            nxt.phase     = hrs_pkg::PH_IDLE;
          end
        end
        default: begin
          decide       = rs && !io_stop && !tick.panel_stop &&
                         (io_start || tick.panel_start);
          nxt.st_start = decide;
          refill       = decide;
          if (refill && tick.weight_above_max) begin
            refill       = 1'b0;
            nxt.st_alarm = 1'b0;
          end
          nxt.st_refill = refill;
          if (refill) begin
            nxt.start_time = tick.time_now;
            nxt.phase      = hrs_pkg::PH_STARTING;
          end
        end
      endcase
    end
  end

  always_comb begin
    status.refill_active   = nxt.st_refill;
    status.release_state   = nxt.release_latch;
    status.start_state     = nxt.st_start;
    status.stop_state      = nxt.st_stop;
    status.timeout_alarm   = nxt.st_alarm;
    status.control_enabled = nxt.panel_used || nxt.software_used;
    case (nxt.phase)
      hrs_pkg::PH_STARTING: status.phase = hrs_pkg::PhaseCodeStarting;
      hrs_pkg::PH_RUNNING:  status.phase = hrs_pkg::PhaseCodeRunning;
      default:              status.phase = hrs_pkg::PhaseCodeIdle;
    endcase
  end

endmodule

// ===== rtl/core/hopper_refill_sequencer.sv =====
// Top level of the hopper refill sequencer: stream ports, tick register,
// sequencer state, result register. Depends on hrs_pkg and hrs_step.
//
// Usage:
//   Each transfer on the s_axis channel is one control tick: time plus the
//   sampled input levels and pulses. Every tick yields exactly one status
//   transfer on m_axis, in order.
//   The cfg channel writes register 0 (refill time limit) or register 1
//   (module enable). It is always ready; write only while no tick is
//   pending. With enable low, ticks leave the state untouched and report it.
// Timing:
//   A tick is captured in the tick register, evaluated against the state
//   (one 32-bit add and compare for the timeout), and the status lands in
//   the result register. One tick per cycle is sustained while m_tready
//   stays high; the state register feeds back to itself through hrs_step.
// Reset:
//   rst (synchronous, active high) clears both valid flags, puts the
//   sequence in idle with all flags low, limit 0 and enable 1.
// Backpressure:
//   When m_tready is low the result register holds; the tick register still
//   takes one more tick, after which s_tready drops until the result moves.
module hopper_refill_sequencer (
  input  logic                           clk,
  input  logic                           rst,
  // tick input
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // time_now[31:0], release_level, request_level, stop_level,
  // startstop_level, panel_start, panel_stop, sw_release_write,
  // sw_release_value, release_toggle, weight_above_max, release_inhibit,
  // zero fill
  input  logic [hrs_pkg::InDataW-1:0]    s_tdata,
  // status output
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // refill_active, release_state, start_state, stop_state, timeout_alarm,
  // phase[1:0], control_enabled
  output logic [hrs_pkg::OutDataW-1:0]   m_tdata,
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [hrs_pkg::CfgIndexW-1:0]  cfg_index,
  input  logic [hrs_pkg::CfgDataW-1:0]   cfg_data
);

  logic                tick_valid;
  hrs_pkg::tick_t      tick;
  hrs_pkg::seq_state_t state;
  hrs_pkg::seq_state_t state_next;
  hrs_pkg::status_t    status_next;
  hrs_pkg::status_t    result;
  hrs_pkg::cfg_t       cfg;
  logic                advance;

  // evaluate the held tick when the result register is free or draining
  assign advance  = tick_valid && (!m_tvalid || m_tready);
  assign s_tready = !tick_valid || advance;
  assign cfg_ready = 1'b1;
  assign m_tdata  = hrs_pkg::OutDataW'(result);

  hrs_step u_step (
    .tick   (tick),
    .cur    (state),
    .cfg    (cfg),
    .nxt    (state_next),
    .status (status_next)
  );

  // tick register
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
    end else if (s_tready) begin
      tick_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      tick <= s_tdata[hrs_pkg::InBits-1:0];
    end
  end

  // sequencer state: advance once per evaluated tick
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase         <= hrs_pkg::PH_IDLE;
      state.start_time    <= '0;
      state.release_latch <= 1'b0;
      state.prev_levels   <= '0;
      state.panel_used    <= 1'b0;
      state.software_used <= 1'b0;
      state.st_refill     <= 1'b0;
      state.st_start      <= 1'b0;
      state.st_stop       <= 1'b0;
      state.st_alarm      <= 1'b0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (advance) begin
      result <= status_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.time_limit <= '0;
      cfg.enable     <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hrs_pkg::RegTimeLimit: cfg.time_limit <= cfg_data;
        hrs_pkg::RegEnable:    cfg.enable     <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule
